// ===== design/cp8_pkg.sv =====
// Shared types and constants for the camera pixel to display byte converter.
// Holds format codes, register indexes, reset values, and the queue and config structs.
`default_nettype none

package cp8_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DIM_W       = 16;
    localparam int OUTW_W      = DIM_W + 1;
    localparam int SPAN_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_IMAGE_HEIGHT = 2'd2;

    localparam logic [3:0] FMT_MONO8   = 4'd0;
    localparam logic [3:0] FMT_MONO10  = 4'd1;
    localparam logic [3:0] FMT_MONO10P = 4'd2;
    localparam logic [3:0] FMT_MONO12  = 4'd3;
    localparam logic [3:0] FMT_MONO12P = 4'd4;
    localparam logic [3:0] FMT_MONO14  = 4'd5;
    localparam logic [3:0] FMT_MONO14P = 4'd6;
    localparam logic [3:0] FMT_MONO16  = 4'd7;
    localparam logic [3:0] FMT_RGB8    = 4'd8;
    localparam logic [3:0] FMT_BGR8    = 4'd9;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 16'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

    localparam int CP8_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [3:0]        fmt;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [OUTW_W-1:0] out_w;
        logic [SPAN_W-1:0] full_span;
        logic [SPAN_W-1:0] full_span_row;
        logic              busy;
        logic              reload;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       pad_last;
        logic       end_last;
    } bundle_t;

endpackage

`default_nettype wire

// ===== design/cp8_cfg.sv =====
// Configuration registers and derived frame span products.
// Depends on cp8_pkg; feeds cp8_front through cfg_t.
`default_nettype none

module cp8_cfg import cp8_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    logic [3:0]        fmt_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [1:0]        busy_reg;
    logic [SPAN_W-1:0] full_span_reg;
    logic [SPAN_W-1:0] full_span_row_reg;
    logic [OUTW_W-1:0] out_w;
    logic [SPAN_W:0]   span_prod;

    assign out_w     = {1'b0, width_reg} + {{DIM_W{1'b0}}, width_reg[0]};
    assign span_prod = {{(SPAN_W + 1 - DIM_W){1'b0}}, height_reg}
                     * {{(SPAN_W + 1 - OUTW_W){1'b0}}, out_w};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= FMT_MONO8;
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            busy_reg   <= SETTLE_CYCLES;
        end else if (wr_en) begin
            case (wr_index)
                CFG_IDX_PIXEL_FORMAT: fmt_reg    <= wr_data[3:0];
                CFG_IDX_IMAGE_WIDTH:  width_reg  <= wr_data[DIM_W-1:0];
                CFG_IDX_IMAGE_HEIGHT: height_reg <= wr_data[DIM_W-1:0];
                default: ;
            endcase
            busy_reg <= SETTLE_CYCLES;
        end else if (busy_reg != 2'd0) begin
            busy_reg <= busy_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        full_span_reg     <= span_prod[SPAN_W-1:0];
        full_span_row_reg <= full_span_reg - {{(SPAN_W - OUTW_W){1'b0}}, out_w};
    end

    always_comb begin
        cfg.fmt           = fmt_reg;
        cfg.width         = width_reg;
        cfg.height        = height_reg;
        cfg.out_w         = out_w;
        cfg.full_span     = full_span_reg;
        cfg.full_span_row = full_span_row_reg;
        cfg.busy          = (busy_reg != 2'd0);
        cfg.reload        = (busy_reg == 2'd1);
    end

endmodule

`default_nettype wire

// ===== design/cp8_front.sv =====
// Front end: accepts raw bytes, tracks group phase, row and column, frame fill,
// and turns each byte into at most one result bundle. Depends on cp8_pkg.
`default_nettype none

module cp8_front import cp8_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_src_byte,
    input  wire logic       s_frame_start,
    input  wire logic       q_full,
    output logic            push,
    output bundle_t         push_data
);

    localparam logic [7:0] MASK_HI6 = 8'b1111_1100;
    localparam logic [7:0] MASK_LO2 = 8'b0000_0011;
    localparam logic [7:0] MASK_HI4 = 8'b1111_0000;
    localparam logic [7:0] MASK_LO4 = 8'b0000_1111;
    localparam logic [7:0] MASK_HI2 = 8'b1100_0000;
    localparam logic [7:0] MASK_LO6 = 8'b0011_1111;

    function automatic logic [7:0] mix10(input logic [7:0] h, input logic [7:0] b);
        return ((h & MASK_HI6) >> 2) | ((b & MASK_LO2) << 6);
    endfunction

    function automatic logic [7:0] mix12(input logic [7:0] h, input logic [7:0] b);
        return ((h & MASK_HI4) >> 4) | ((b & MASK_LO4) << 4);
    endfunction

    function automatic logic [7:0] mix14(input logic [7:0] h, input logic [7:0] b);
        return ((h & MASK_HI2) >> 6) | ((b & MASK_LO6) << 2);
    endfunction

    function automatic logic [2:0] group_len(input logic [3:0] fmt);
        logic [2:0] len;
        case (fmt)
            FMT_MONO8:   len = 3'd1;
            FMT_MONO10P: len = 3'd5;
            FMT_MONO12P: len = 3'd3;
            FMT_MONO14P: len = 3'd7;
            FMT_RGB8:    len = 3'd3;
            FMT_BGR8:    len = 3'd3;
            default:     len = 3'd2;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] group_pixels(input logic [3:0] fmt);
        logic [2:0] grp;
        case (fmt)
            FMT_MONO10P: grp = 3'd4;
            FMT_MONO14P: grp = 3'd4;
            FMT_MONO12P: grp = 3'd2;
            default:     grp = 3'd0;
        endcase
        return grp;
    endfunction

    logic [2:0]        phase_reg, phase_next;
    logic [15:0]       held_reg, held_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic              full_reg, full_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [SPAN_W-1:0] span_row_reg, span_row_next;
    logic [SPAN_W-1:0] rowmul_reg;

    logic [2:0]        cur_phase;
    logic [15:0]       cur_held;
    logic [DIM_W-1:0]  cur_col;
    logic [DIM_W-1:0]  cur_row;
    logic              cur_full;
    logic [SPAN_W-1:0] cur_span;
    logic [SPAN_W-1:0] cur_span_row;

    logic [DIM_W-1:0]  rows_left;
    logic [SPAN_W:0]   rows_prod;
    logic [SPAN_W-1:0] out_w_ext;

    logic              accept;
    logic              fmt_ok;
    logic [2:0]        len;
    logic [2:0]        grp;
    logic [2:0]        ph;
    logic              group_last;
    logic              emit;
    logic              px_done;
    logic              grey;
    logic              bgr_out;
    logic              row_end;
    logic              pad;
    logic              full_hit;
    logic              end_hit;
    logic [7:0]        px;
    logic [7:0]        b;
    logic [7:0]        h;
    logic [DIM_W-1:0]  col1;
    logic [DIM_W-1:0]  row1;
    logic [DIM_W:0]    need0;
    logic [DIM_W:0]    need1;

    assign s_ready = !cfg.busy && !q_full;
    assign accept  = s_valid && s_ready;

    assign cur_phase    = s_frame_start ? 3'd0 : phase_reg;
    assign cur_held     = s_frame_start ? 16'd0 : held_reg;
    assign cur_col      = s_frame_start ? '0 : col_reg;
    assign cur_row      = s_frame_start ? '0 : row_reg;
    assign cur_full     = s_frame_start ? 1'b0 : full_reg;
    assign cur_span     = s_frame_start ? cfg.full_span : span_reg;
    assign cur_span_row = s_frame_start ? cfg.full_span_row : span_row_reg;

    assign out_w_ext = {{(SPAN_W - OUTW_W){1'b0}}, cfg.out_w};
    assign rows_left = (row_reg < cfg.height) ? cfg.height - row_reg : '0;
    assign rows_prod = {{(SPAN_W + 1 - DIM_W){1'b0}}, rows_left}
                     * {{(SPAN_W + 1 - OUTW_W){1'b0}}, cfg.out_w};

    assign b      = s_src_byte;
    assign h      = cur_held[7:0];
    assign fmt_ok = (cfg.fmt <= FMT_BGR8);
    assign len    = group_len(cfg.fmt);
    assign grp    = group_pixels(cfg.fmt);
    assign col1   = cur_col + 16'd1;
    assign row1   = cur_row + 16'd1;
    assign need0  = {1'b0, cur_col} + {{(DIM_W - 2){1'b0}}, grp};
    assign need1  = {1'b0, col1} + {{(DIM_W - 2){1'b0}}, grp};

    always_comb begin
        phase_next    = cur_phase;
        held_next     = cur_held;
        col_next      = cur_col;
        row_next      = cur_row;
        full_next     = cur_full;
        span_next     = cur_span;
        span_row_next = cur_span_row;
        ph            = 3'd0;
        group_last    = 1'b0;
        emit          = 1'b0;
        px_done       = 1'b0;
        grey          = 1'b0;
        bgr_out       = 1'b0;
        row_end       = 1'b0;
        pad           = 1'b0;
        full_hit      = 1'b0;
        end_hit       = 1'b0;
        px            = b;

        if (fmt_ok && cfg.width != '0 && cfg.height != '0 && !cur_full) begin
            if (cur_row >= cfg.height) begin
                full_next = 1'b1;
            end else begin
                ph         = (cur_phase >= len) ? 3'd0 : cur_phase;
                phase_next = ph;
                if (grp != 3'd0 && ph == 3'd0
                        && cur_span < {{(SPAN_W - DIM_W - 1){1'b0}}, need0}) begin
                    full_next = 1'b1;
                end else begin
                    group_last = (ph + 3'd1) == len;
                    phase_next = group_last ? 3'd0 : ph + 3'd1;
                    case (cfg.fmt)
                        FMT_MONO8: begin
                            emit = 1'b1;
                        end
                        FMT_MONO10, FMT_MONO12, FMT_MONO14, FMT_MONO16: begin
                            if (ph == 3'd0) begin
                                held_next = {8'd0, b};
                            end else begin
                                emit = 1'b1;
                                case (cfg.fmt)
                                    FMT_MONO10: px = mix10(h, b);
                                    FMT_MONO12: px = mix12(h, b);
                                    FMT_MONO14: px = mix14(h, b);
                                    default:    px = b;
                                endcase
                            end
                        end
                        FMT_MONO10P: begin
                            held_next = {8'd0, b};
                            emit      = (ph != 3'd0);
                            case (ph)
                                3'd1:    px = mix10(h, b);
                                3'd2:    px = mix12(h, b);
                                3'd3:    px = mix14(h, b);
                                default: px = b;
                            endcase
                        end
                        FMT_MONO12P: begin
                            held_next = {8'd0, b};
                            emit      = (ph != 3'd0);
                            px        = (ph == 3'd1) ? mix12(h, b) : b;
                        end
                        FMT_MONO14P: begin
                            held_next = {8'd0, b};
                            emit      = (ph inside {3'd1, 3'd3, 3'd5, 3'd6});
                            case (ph)
                                3'd1:    px = mix14(h, b);
                                3'd3:    px = mix12(h, b);
                                3'd5:    px = mix10(h, b);
                                default: px = b;
                            endcase
                        end
                        FMT_RGB8: begin
                            emit    = 1'b1;
                            px_done = (ph == 3'd2);
                        end
                        default: begin
                            if (ph == 3'd0) begin
                                held_next = {8'd0, b};
                            end else if (ph == 3'd1) begin
                                held_next = {b, cur_held[7:0]};
                            end else begin
                                emit    = 1'b1;
                                bgr_out = 1'b1;
                                px_done = 1'b1;
                            end
                        end
                    endcase

                    grey = (cfg.fmt inside {[FMT_MONO8:FMT_MONO16]});
                    if (grey) begin
                        px_done = emit;
                    end

                    if (emit) begin
                        if (px_done) begin
                            col_next = col1;
                            if (col1 >= cfg.width) begin
                                row_end       = 1'b1;
                                col_next      = '0;
                                row_next      = row1;
                                span_next     = cur_span_row;
                                span_row_next = cur_span_row - out_w_ext;
                                pad           = grey && cfg.width[0];
                                if (row1 >= cfg.height) begin
                                    full_hit  = 1'b1;
                                    full_next = 1'b1;
                                end
                            end
                        end
                        if (grp != 3'd0 && group_last && !full_hit) begin
                            if (row_end ? (cur_span_row < {{(SPAN_W - 3){1'b0}}, grp})
                                        : (cur_span < {{(SPAN_W - DIM_W - 1){1'b0}}, need1})) begin
                                end_hit   = 1'b1;
                                full_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        push               = accept && emit;
        push_data.cnt      = bgr_out ? 2'd3 : (pad ? 2'd2 : 2'd1);
        push_data.byte0    = px;
        push_data.byte1    = bgr_out ? cur_held[15:8] : 8'd0;
        push_data.byte2    = cur_held[7:0];
        push_data.pad_last = pad;
        push_data.end_last = full_hit || end_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 3'd0;
            held_reg     <= 16'd0;
            col_reg      <= '0;
            row_reg      <= '0;
            full_reg     <= 1'b0;
            span_reg     <= '0;
            span_row_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            full_reg     <= full_next;
            span_reg     <= span_next;
            span_row_reg <= span_row_next;
        end else if (cfg.reload) begin
            span_reg     <= rowmul_reg;
            span_row_reg <= rowmul_reg - out_w_ext;
        end
    end

    always_ff @(posedge aclk) begin
        rowmul_reg <= rows_prod[SPAN_W-1:0];
    end

endmodule

`default_nettype wire

// ===== design/cp8_queue.sv =====
// Short queue of result bundles between the front end and the output stage.
// Depends on cp8_pkg for bundle_t.
`default_nettype none

module cp8_queue import cp8_pkg::*; #(
    parameter int DEPTH = CP8_QUEUE_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire bundle_t push_data,
    output logic         full,
    input  wire logic    pop,
    output bundle_t      pop_data,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    bundle_t          slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/cp8_back.sv =====
// Output stage: holds one result bundle and hands out its results one request at a time.
// Depends on cp8_pkg for bundle_t.
`default_nettype none

module cp8_back import cp8_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    empty,
    input  wire bundle_t pop_data,
    output logic         pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_is_pad,
    output logic         m_frame_end,
    output logic         m_last_of_step
);

    bundle_t    cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       last;
    logic       take;

    assign last    = valid_reg && ((idx_reg + 2'd1) == cur_reg.cnt);
    assign take    = valid_reg && m_ready;
    assign pop     = !empty && (!valid_reg || (m_ready && last));
    assign m_valid = valid_reg;

    always_comb begin
        case (idx_reg)
            2'd0:    m_out_byte = cur_reg.byte0;
            2'd1:    m_out_byte = cur_reg.byte1;
            default: m_out_byte = cur_reg.byte2;
        endcase
        m_is_pad       = last && cur_reg.pad_last;
        m_frame_end    = last && cur_reg.end_last;
        m_last_of_step = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (take) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/camera_pixel_to_display8_converter_top.sv =====
// Top level of the camera pixel to display byte converter.
// Depends on cp8_pkg, cp8_cfg, cp8_front, cp8_queue and cp8_back.
//
// Takes one raw camera byte per clock while s_ready is high and gives one display
// byte per clock while m_ready is high. A byte enters in the cycle it is accepted;
// its first result passes through a queue slot and the output stage register before
// it can be taken. Most bytes give zero or one result; the last pixel of an odd grey
// row gives two (pixel, then zero pad) and the third byte of a BGR8 triple gives three,
// so the sustained output is one result per clock and the input rate is set by the
// result count per byte. QUEUE_DEPTH result groups sit between input and output; when
// it is full, s_ready drops. After reset and after every configuration write, s_ready
// stays low while the frame span products (height times padded width) refresh.
`default_nettype none

module camera_pixel_to_display8_converter_top import cp8_pkg::*; #(
    parameter int QUEUE_DEPTH = CP8_QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_src_byte,
    input  wire logic                   s_frame_start,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_is_pad,
    output logic                        m_frame_end,
    output logic                        m_last_of_step
);

    cfg_t    cfg;
    bundle_t push_data;
    bundle_t pop_data;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;

    assign cfg_ready = 1'b1;

    cp8_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cp8_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_src_byte    (s_src_byte),
        .s_frame_start (s_frame_start),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    cp8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    cp8_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (q_empty),
        .pop_data       (pop_data),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_is_pad       (m_is_pad),
        .m_frame_end    (m_frame_end),
        .m_last_of_step (m_last_of_step)
    );

endmodule

`default_nettype wire
